>>> rtl/keystroke_integer_calculator_unit_assert.svh
// Assertion macros for the keypad calculator.
// Used inside modules that have clk and rst in scope; no other dependencies.
`ifndef KEYSTROKE_INTEGER_CALCULATOR_UNIT_ASSERT_SVH
`define KEYSTROKE_INTEGER_CALCULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, off while rst is high.
`define KIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst is high.
`define KIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kic_pkg.sv
// Package for the keypad calculator: key codes, operator codes, widths.
// No dependencies.
`default_nettype none

package kic_pkg;

  localparam int DATA_W    = 32;
  localparam int QUOT_W    = 2 * DATA_W;
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = QUOT_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [QUOT_W-1:0] QUOT_MAX = {1'b0, {(QUOT_W-1){1'b1}}};

  localparam logic [7:0] KEY_ZERO   = 8'd48;
  localparam logic [7:0] KEY_NINE   = 8'd57;
  localparam logic [7:0] KEY_EQUALS = 8'd61;
  localparam logic [7:0] KEY_PLUS   = 8'h2B;
  localparam logic [7:0] KEY_MINUS  = 8'h2D;
  localparam logic [7:0] KEY_STAR   = 8'h2A;
  localparam logic [7:0] KEY_SLASH  = 8'h2F;
  localparam logic [7:0] KEY_PCT    = 8'h25;
  localparam logic [7:0] KEY_AMP    = 8'h26;
  localparam logic [7:0] KEY_CARET  = 8'h5E;
  localparam logic [7:0] KEY_BAR    = 8'h7C;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_AND = 3'd5,
    OP_XOR = 3'd6,
    OP_OR  = 3'd7
  } op_t;

  typedef struct packed {
    logic hit;
    op_t  op;
  } key_op_t;

  function automatic key_op_t decode_op(input logic [7:0] k);
    key_op_t r;
    r.hit = 1'b1;
    r.op  = OP_ADD;
    case (k)
      KEY_PLUS:  r.op = OP_ADD;
      KEY_MINUS: r.op = OP_SUB;
      KEY_STAR:  r.op = OP_MUL;
      KEY_SLASH: r.op = OP_DIV;
      KEY_PCT:   r.op = OP_MOD;
      KEY_AMP:   r.op = OP_AND;
      KEY_CARET: r.op = OP_XOR;
      KEY_BAR:   r.op = OP_OR;
      default:   r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/keystroke_integer_calculator_unit.sv
// Keypad integer calculator: key decode, operand entry and a bit-serial
// shift-add multiplier / shift-subtract divider. Depends on kic_pkg and
// keystroke_integer_calculator_unit_assert.svh.
//
//  - Input channel (in_valid/in_ready, key_code): one ASCII key per beat.
//    Digits build the first operand, an operator key (+ - * / % & ^ |)
//    switches to the second operand, '=' runs the operation. Other keys,
//    '=' before an operator and operators after one are dropped.
//  - Output channel (out_valid/out_ready): one result beat per '='.
//    int_result for + - * % & ^ |, quotient_fixed (signed Q32.32,
//    truncated, saturated) for '/', error_code on divide or modulo by zero.
//  - Digit, operator and ignored keys leave the block idle and ready for the next key.
//  - '=' occupies the block through SETUP, then ITER for * (one
//    multiplier bit per cycle) and for / and % (one quotient bit per
//    cycle over a 64-bit dividend; ITER is skipped on a zero divisor and
//    for + - & ^ |), then FINISH, after which the result sits in the output register.
//  - A waiting result does not block keys; a second result ready before
//    the first is taken holds in the datapath and stops key intake.
//  - Reset (rst, synchronous) clears the operands, the phase, the
//    sequencer and the output valid flag.
`default_nettype none
`include "keystroke_integer_calculator_unit_assert.svh"

module keystroke_integer_calculator_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [7:0]                           key_code,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [kic_pkg::DATA_W-1:0]    int_result,
  output logic signed [kic_pkg::QUOT_W-1:0]    quotient_fixed,
  output logic                                 is_division,
  output logic                                 error_code
);
  import kic_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_ITER   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  // expression entry
  logic                     phase;
  logic [OPERAND_WIDTH-1:0] first_operand;
  logic [OPERAND_WIDTH-1:0] second_operand;
  op_t                      op;

  // working operands, sign-extended to 32 bits
  logic [DATA_W-1:0]        a_w;
  logic [DATA_W-1:0]        b_w;

  // shared serial datapath
  // mul: acc = product, dsr = multiplicand (shifts left), sreg = multiplier (shifts right)
  // div: acc = remainder, dsr = divisor, sreg = dividend in / quotient out
  logic [DATA_W-1:0]        acc;
  logic [DATA_W-1:0]        dsr;
  logic [QUOT_W-1:0]        sreg;
  logic [CNT_W-1:0]         cnt;
  logic                     err;

  logic                     accept;
  logic                     is_digit;
  logic [3:0]               digit;
  key_op_t                  kop;
  logic [OPERAND_WIDTH-1:0] first_next;
  logic [OPERAND_WIDTH-1:0] second_next;
  logic [DATA_W:0]          div_sh;
  logic [DATA_W:0]          div_diff;
  logic [CNT_W-1:0]         cnt_last;
  logic                     out_free;
  logic [QUOT_W-1:0]        quot_res;
  logic [DATA_W-1:0]        mod_res;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_digit = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
  assign digit    = 4'(key_code - KEY_ZERO);
  assign kop      = decode_op(key_code);

  // x*10 + d as two shifted adds, wrapping at the operand width
  assign first_next  = {first_operand[OPERAND_WIDTH-4:0], 3'b000}
                     + {first_operand[OPERAND_WIDTH-2:0], 1'b0}
                     + OPERAND_WIDTH'(digit);
  assign second_next = {second_operand[OPERAND_WIDTH-4:0], 3'b000}
                     + {second_operand[OPERAND_WIDTH-2:0], 1'b0}
                     + OPERAND_WIDTH'(digit);

  // restoring division step
  assign div_sh   = {acc, sreg[QUOT_W-1]};
  assign div_diff = div_sh - {1'b0, dsr};

  assign cnt_last = (op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
  assign out_free = !out_valid || out_ready;

  // sign fixups; the only positive overflow is a quotient of exactly 2^63
  always_comb begin
    if (a_w[DATA_W-1] ^ b_w[DATA_W-1]) begin
      quot_res = QUOT_W'(0) - sreg;
    end else if (sreg[QUOT_W-1]) begin
      quot_res = QUOT_MAX;
    end else begin
      quot_res = sreg;
    end
    mod_res = a_w[DATA_W-1] ? (DATA_W'(0) - acc) : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= 1'b0;
      first_operand  <= '0;
      second_operand <= '0;
      op             <= OP_ADD;
      out_valid      <= 1'b0;
      err            <= 1'b0;
      cnt            <= '0;
    end else begin
      // a beat taken while a new result loads is covered by the load below
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!phase) begin
              if (is_digit) begin
                first_operand <= first_next;
              end else if (kop.hit) begin
                op    <= kop.op;
                phase <= 1'b1;
              end
            end else if (is_digit) begin
              second_operand <= second_next;
            end else if (key_code == KEY_EQUALS) begin
              // latch the expression and clear entry state for the next one
              a_w            <= DATA_W'($signed(first_operand));
              b_w            <= DATA_W'($signed(second_operand));
              first_operand  <= '0;
              second_operand <= '0;
              phase          <= 1'b0;
              state          <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          err <= 1'b0;
          cnt <= '0;
          case (op)
            OP_ADD: begin
              acc   <= a_w + b_w;
              state <= ST_FINISH;
            end
            OP_SUB: begin
              acc   <= a_w - b_w;
              state <= ST_FINISH;
            end
            OP_AND: begin
              acc   <= a_w & b_w;
              state <= ST_FINISH;
            end
            OP_XOR: begin
              acc   <= a_w ^ b_w;
              state <= ST_FINISH;
            end
            OP_OR: begin
              acc   <= a_w | b_w;
              state <= ST_FINISH;
            end
            OP_MUL: begin
              acc   <= '0;
              dsr   <= a_w;
              sreg  <= QUOT_W'(b_w);
              state <= ST_ITER;
            end
            OP_DIV, OP_MOD: begin
              acc <= '0;
              dsr <= mag(b_w);
              // '/' divides |a| * 2^32; '%' divides |a| itself
              if (op == OP_DIV) begin
                sreg <= {mag(a_w), DATA_W'(0)};
              end else begin
                sreg <= QUOT_W'(mag(a_w));
              end
              if (b_w == '0) begin
                err   <= 1'b1;
                state <= ST_FINISH;
              end else begin
                state <= ST_ITER;
              end
            end
            default: state <= ST_FINISH;
          endcase
        end
        ST_ITER: begin
          if (op == OP_MUL) begin
            if (sreg[0]) begin
              acc <= acc + dsr;
            end
            dsr  <= {dsr[DATA_W-2:0], 1'b0};
            sreg <= {1'b0, sreg[QUOT_W-1:1]};
          end else if (!div_diff[DATA_W]) begin
            acc  <= div_diff[DATA_W-1:0];
            sreg <= {sreg[QUOT_W-2:0], 1'b1};
          end else begin
            acc  <= div_sh[DATA_W-1:0];
            sreg <= {sreg[QUOT_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == cnt_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register, payload only
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      is_division <= (op == OP_DIV);
      error_code  <= err;
      if (err || op == OP_DIV) begin
        int_result <= '0;
      end else if (op == OP_MOD) begin
        int_result <= mod_res;
      end else begin
        int_result <= acc;
      end
      if (op == OP_DIV && !err) begin
        quotient_fixed <= quot_res;
      end else begin
        quotient_fixed <= '0;
      end
    end
  end

  `KIC_ASSERT_NOW(a_err_zeroes, out_valid && error_code, int_result == '0 && quotient_fixed == '0, "error result carries nonzero data")
  `KIC_ASSERT_NOW(a_quot_only_div, out_valid && !is_division, quotient_fixed == '0, "quotient set for a non-division result")
  `KIC_ASSERT_NEXT(a_finish_loads, state == ST_FINISH && out_free, out_valid && state == ST_IDLE, "finished result not loaded")
  `KIC_ASSERT_NEXT(a_equals_clears, accept && phase && key_code == KEY_EQUALS, !phase && first_operand == '0 && second_operand == '0 && state == ST_SETUP, "entry state not cleared after equals")

endmodule

`default_nettype wire
